// File: rtl/core/ismf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ITCH symbol message filter package
// Shared constants, codes, the message length table and the types that
// travel between the front end, the queue and the back end.
// ----------------------------------------------------------------------------
package ismf_pkg;

   // Sizing
   localparam int NUM_SYMBOLS   = 4;    // symbol slots, 1..8
   localparam int SYMBOL_REGS   = 4;    // symbol registers on the CSR map
   localparam int LOCATE_BITS   = 16;   // locate bits that index the marks, 8..16
   localparam int SYMBOL_W      = 64;
   localparam int CNT_W         = 48;
   localparam int CSR_IDX_W     = 3;
   localparam int ROW_BITS      = 6;    // 64 marks per memory row
   localparam int ROW_W         = 1 << ROW_BITS;
   localparam int MARK_ROW_BITS = LOCATE_BITS - ROW_BITS;
   localparam int MARK_ROWS     = 1 << MARK_ROW_BITS;
   localparam int QUEUE_DEPTH   = 4;    // power of two
   localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

   localparam logic [15:0] MIN_LEN    = 16'd12;
   localparam logic [1:0]  PREFIX_LEN = 2'd2;

   localparam logic [7:0] TYPE_SYSTEM    = "S";
   localparam logic [7:0] TYPE_DIRECTORY = "R";

   // CSR register map
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SYMBOL_0     = 3'd0,
      REG_SYMBOL_1     = 3'd1,
      REG_SYMBOL_2     = 3'd2,
      REG_SYMBOL_3     = 3'd3,
      REG_SYMBOL_COUNT = 3'd4,
      REG_BYTE_CEILING = 3'd5
   } csr_reg_type;

   typedef enum logic [2:0] {
      VERDICT_DROP     = 3'd0,
      VERDICT_KEEP     = 3'd1,
      VERDICT_CEIL     = 3'd2,
      VERDICT_SHORT    = 3'd3,
      VERDICT_MISMATCH = 3'd4,
      VERDICT_HALTED   = 3'd5
   } verdict_type;

   typedef enum logic [1:0] {
      LEN_OK,
      LEN_SHORT,
      LEN_MISMATCH
   } len_check_type;

   typedef enum logic [1:0] {
      KIND_SYSTEM,
      KIND_DIRECTORY,
      KIND_OTHER
   } msg_kind_type;

   typedef struct packed {
      logic [NUM_SYMBOLS-1:0][SYMBOL_W-1:0] symbols;
      logic [2:0]                           symbol_count;
      logic [CNT_W-1:0]                     byte_ceiling;
   } cfg_type;

   // One classified message as it waits for the back end
   typedef struct packed {
      logic [7:0]             msg_type;
      logic [LOCATE_BITS-1:0] loc;
      logic [15:0]            msg_length;
      len_check_type          len_check;
      msg_kind_type           kind;
      logic                   dir_match;
      logic                   spec_known;
   } work_type;

   // ITCH 5.0 message lengths; zero for any type not in the table
   function automatic logic [7:0] msg_body_len(input logic [7:0] t);
      logic [7:0] len;
      unique case (t)
         "S":     len = 8'd12;
         "R":     len = 8'd39;
         "H":     len = 8'd25;
         "Y":     len = 8'd20;
         "L":     len = 8'd26;
         "V":     len = 8'd35;
         "W":     len = 8'd12;
         "K":     len = 8'd28;
         "J":     len = 8'd35;
         "h":     len = 8'd21;
         "A":     len = 8'd36;
         "F":     len = 8'd40;
         "E":     len = 8'd31;
         "C":     len = 8'd36;
         "X":     len = 8'd23;
         "D":     len = 8'd19;
         "U":     len = 8'd35;
         "P":     len = 8'd44;
         "Q":     len = 8'd40;
         "B":     len = 8'd19;
         "I":     len = 8'd50;
         "N":     len = 8'd20;
         "O":     len = 8'd48;
         default: len = 8'd0;
      endcase
      return len;
   endfunction

endpackage

// File: rtl/core/ismf_csr.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISMF configuration registers
// Symbol slots, symbol count and byte ceiling, written over the CSR channel.
// ----------------------------------------------------------------------------
module ismf_csr (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [ismf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ismf_pkg::SYMBOL_W-1:0]  csr_data,
   output ismf_pkg::cfg_type             cfg
);
   import ismf_pkg::*;

   logic [NUM_SYMBOLS-1:0][SYMBOL_W-1:0] symbols_ff;
   logic [2:0]                           symbol_count_ff;
   logic [CNT_W-1:0]                     byte_ceiling_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         symbols_ff      <= '0;
         symbol_count_ff <= '0;
         byte_ceiling_ff <= CNT_W'(1048576);
      end else if (csr_valid) begin
         // slots past the register map stay zero
         for (int i = 0; i < NUM_SYMBOLS; i++) begin
            if (i < SYMBOL_REGS && csr_index == CSR_IDX_W'(i)) begin
               symbols_ff[i] <= csr_data;
            end
         end
         if (csr_index == REG_SYMBOL_COUNT) begin
            symbol_count_ff <= csr_data[2:0];
         end
         if (csr_index == REG_BYTE_CEILING) begin
            byte_ceiling_ff <= csr_data[CNT_W-1:0];
         end
      end
   end

   assign cfg.symbols      = symbols_ff;
   assign cfg.symbol_count = symbol_count_ff;
   assign cfg.byte_ceiling = byte_ceiling_ff;

endmodule

// File: rtl/core/ismf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISMF front end
// Accepts message headers, checks the length and matches directory symbols.
// ----------------------------------------------------------------------------
module ismf_front (
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_msg_type,
   input  logic [15:0]                   req_stock_locate,
   input  logic [15:0]                   req_msg_length,
   input  logic [ismf_pkg::SYMBOL_W-1:0] req_stock_field,
   input  ismf_pkg::cfg_type             cfg,
   input  logic                          queue_full,
   input  logic                          clear_busy,
   output logic                          push,
   output ismf_pkg::work_type            push_item
);
   import ismf_pkg::*;

   logic [7:0] spec;
   logic [3:0] slots_used;
   logic       match;

   assign req_ready = !queue_full && !clear_busy;
   assign push      = req_valid && req_ready;

   always_comb begin
      spec = msg_body_len(req_msg_type);

      // symbol count saturates at the number of slots
      if ({1'b0, cfg.symbol_count} > 4'(NUM_SYMBOLS)) begin
         slots_used = 4'(NUM_SYMBOLS);
      end else begin
         slots_used = {1'b0, cfg.symbol_count};
      end

      match = 1'b0;
      for (int i = 0; i < NUM_SYMBOLS; i++) begin
         if (4'(i) < slots_used && cfg.symbols[i] == req_stock_field) begin
            match = 1'b1;
         end
      end

      push_item.msg_type   = req_msg_type;
      push_item.loc        = req_stock_locate[LOCATE_BITS-1:0];
      push_item.msg_length = req_msg_length;
      push_item.dir_match  = match;
      push_item.spec_known = (spec != 8'd0);

      priority if (req_msg_length < MIN_LEN) begin
         push_item.len_check = LEN_SHORT;
      end else if (spec != 8'd0 && req_msg_length != {8'd0, spec}) begin
         push_item.len_check = LEN_MISMATCH;
      end else begin
         push_item.len_check = LEN_OK;
      end

      priority if (req_msg_type == TYPE_SYSTEM) begin
         push_item.kind = KIND_SYSTEM;
      end else if (req_msg_type == TYPE_DIRECTORY) begin
         push_item.kind = KIND_DIRECTORY;
      end else begin
         push_item.kind = KIND_OTHER;
      end
   end

endmodule

// File: rtl/core/ismf_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISMF work queue
// Short FIFO of classified messages between the front and back ends.
// ----------------------------------------------------------------------------
module ismf_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  ismf_pkg::work_type push_item,
   input  logic               pop,
   output logic               head_valid,
   output ismf_pkg::work_type head_item,
   output logic               full
);
   import ismf_pkg::*;

   work_type          entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff,  count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      unique case ({push, pop})
         2'b10:   count_in = count_ff + (QPTR_W+1)'(1);
         2'b01:   count_in = count_ff - (QPTR_W+1)'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];
   assign full       = (count_ff == (QPTR_W+1)'(QUEUE_DEPTH));

endmodule

// File: rtl/core/ismf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISMF back end
// Locate marks, type census, running counters, halt and the result register.
// ----------------------------------------------------------------------------
module ismf_back (
   input  logic                       clock,
   input  logic                       reset,
   input  ismf_pkg::cfg_type          cfg,
   input  logic                       head_valid,
   input  ismf_pkg::work_type         head_item,
   output logic                       pop,
   output logic                       clear_busy,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [2:0]                 rsp_verdict,
   output logic [ismf_pkg::CNT_W-1:0] rsp_bytes_kept_total,
   output logic [ismf_pkg::CNT_W-1:0] rsp_frames_kept_total,
   output logic [ismf_pkg::CNT_W-1:0] rsp_type_kept_count,
   output logic [ismf_pkg::CNT_W-1:0] rsp_unknown_kept_total
);
   import ismf_pkg::*;

   // mark clearing sweep after reset
   logic                     clr_busy_ff;
   logic [MARK_ROW_BITS-1:0] clr_row_ff;

   // memories
   logic [ROW_W-1:0] mark_mem [MARK_ROWS];
   logic [CNT_W-1:0] census_mem [256];
   logic [255:0]     census_vld_ff;

   // execute stage
   logic             b2_valid_ff, b2_valid_in;
   work_type         b2_item_ff;
   logic [ROW_W-1:0] mark_rd_ff;
   logic [CNT_W-1:0] census_rd_ff;
   logic             census_rd_vld_ff;
   logic             b2_go;

   // last write to each memory, for a read that raced it
   logic                     mfwd_vld_ff;
   logic [MARK_ROW_BITS-1:0] mfwd_row_ff;
   logic [ROW_W-1:0]         mfwd_data_ff;
   logic                     cfwd_vld_ff;
   logic [7:0]               cfwd_addr_ff;
   logic [CNT_W-1:0]         cfwd_data_ff;

   // running state
   logic [CNT_W-1:0] kept_bytes_ff,   kept_bytes_in;
   logic [CNT_W-1:0] kept_frames_ff,  kept_frames_in;
   logic [CNT_W-1:0] kept_unknown_ff, kept_unknown_in;
   logic             halted_ff,       halted_in;

   // result register
   logic             rsp_valid_ff;
   verdict_type      rsp_verdict_ff;
   logic [CNT_W-1:0] rsp_bytes_ff, rsp_frames_ff, rsp_type_ff, rsp_unknown_ff;

   // execute-stage logic
   logic [MARK_ROW_BITS-1:0] b2_row;
   logic [ROW_W-1:0]         mark_row_cur, mark_row_new;
   logic                     mark_bit, keep, mark_set, census_set;
   logic [CNT_W-1:0]         census_cur, census_new;
   logic [CNT_W:0]           bytes_next;
   verdict_type              verdict;

   logic                     mark_we;
   logic [MARK_ROW_BITS-1:0] mark_wa;
   logic [ROW_W-1:0]         mark_wd;

   assign b2_go      = b2_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign pop        = head_valid && !clr_busy_ff && (!b2_valid_ff || b2_go);
   assign clear_busy = clr_busy_ff;
   assign b2_row     = b2_item_ff.loc[LOCATE_BITS-1:ROW_BITS];

   always_comb begin
      b2_valid_in = b2_valid_ff;
      if (pop) begin
         b2_valid_in = 1'b1;
      end else if (b2_go) begin
         b2_valid_in = 1'b0;
      end

      if (mfwd_vld_ff && mfwd_row_ff == b2_row) begin
         mark_row_cur = mfwd_data_ff;
      end else begin
         mark_row_cur = mark_rd_ff;
      end
      mark_bit     = mark_row_cur[b2_item_ff.loc[ROW_BITS-1:0]];
      mark_row_new = mark_row_cur | (ROW_W'(1) << b2_item_ff.loc[ROW_BITS-1:0]);

      priority if (cfwd_vld_ff && cfwd_addr_ff == b2_item_ff.msg_type) begin
         census_cur = cfwd_data_ff;
      end else if (census_rd_vld_ff) begin
         census_cur = census_rd_ff;
      end else begin
         census_cur = '0;
      end
      census_new = census_cur + CNT_W'(1);

      unique case (b2_item_ff.kind)
         KIND_SYSTEM:    keep = 1'b1;
         KIND_DIRECTORY: keep = b2_item_ff.dir_match;
         default:        keep = mark_bit;
      endcase

      bytes_next = {1'b0, kept_bytes_ff} + (CNT_W+1)'(b2_item_ff.msg_length)
                   + (CNT_W+1)'(PREFIX_LEN);

      mark_set = 1'b0;
      priority if (halted_ff) begin
         verdict = VERDICT_HALTED;
      end else if (b2_item_ff.len_check == LEN_SHORT) begin
         verdict = VERDICT_SHORT;
      end else if (b2_item_ff.len_check == LEN_MISMATCH) begin
         verdict = VERDICT_MISMATCH;
      end else begin
         // a matching directory entry marks its locate even at the ceiling
         mark_set = (b2_item_ff.kind == KIND_DIRECTORY) && b2_item_ff.dir_match;
         priority if (!keep) begin
            verdict = VERDICT_DROP;
         end else if (bytes_next > {1'b0, cfg.byte_ceiling}) begin
            verdict = VERDICT_CEIL;
         end else begin
            verdict = VERDICT_KEEP;
         end
      end
      mark_set   = mark_set && b2_go;
      census_set = b2_go && (verdict == VERDICT_KEEP);

      kept_bytes_in   = kept_bytes_ff;
      kept_frames_in  = kept_frames_ff;
      kept_unknown_in = kept_unknown_ff;
      halted_in       = halted_ff;
      if (b2_go) begin
         if (verdict == VERDICT_SHORT || verdict == VERDICT_MISMATCH
             || verdict == VERDICT_CEIL) begin
            halted_in = 1'b1;
         end
         if (verdict == VERDICT_KEEP) begin
            kept_bytes_in  = bytes_next[CNT_W-1:0];
            kept_frames_in = kept_frames_ff + CNT_W'(1);
            if (!b2_item_ff.spec_known) begin
               kept_unknown_in = kept_unknown_ff + CNT_W'(1);
            end
         end
      end

      mark_we = clr_busy_ff || mark_set;
      mark_wa = clr_busy_ff ? clr_row_ff : b2_row;
      mark_wd = clr_busy_ff ? '0 : mark_row_new;
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_busy_ff     <= 1'b1;
         clr_row_ff      <= '0;
         b2_valid_ff     <= 1'b0;
         mfwd_vld_ff     <= 1'b0;
         cfwd_vld_ff     <= 1'b0;
         kept_bytes_ff   <= '0;
         kept_frames_ff  <= '0;
         kept_unknown_ff <= '0;
         halted_ff       <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         census_vld_ff   <= '0;
      end else begin
         if (clr_busy_ff) begin
            clr_row_ff <= clr_row_ff + MARK_ROW_BITS'(1);
            if (clr_row_ff == MARK_ROW_BITS'(MARK_ROWS - 1)) begin
               clr_busy_ff <= 1'b0;
            end
         end
         b2_valid_ff     <= b2_valid_in;
         kept_bytes_ff   <= kept_bytes_in;
         kept_frames_ff  <= kept_frames_in;
         kept_unknown_ff <= kept_unknown_in;
         halted_ff       <= halted_in;
         if (mark_set) begin
            mfwd_vld_ff <= 1'b1;
         end
         if (census_set) begin
            cfwd_vld_ff                         <= 1'b1;
            census_vld_ff[b2_item_ff.msg_type] <= 1'b1;
         end
         if (b2_go) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload and memories
   always_ff @(posedge clock) begin
      if (mark_we) begin
         mark_mem[mark_wa] <= mark_wd;
      end
      if (census_set) begin
         census_mem[b2_item_ff.msg_type] <= census_new;
      end
      if (pop) begin
         b2_item_ff       <= head_item;
         mark_rd_ff       <= mark_mem[head_item.loc[LOCATE_BITS-1:ROW_BITS]];
         census_rd_ff     <= census_mem[head_item.msg_type];
         census_rd_vld_ff <= census_vld_ff[head_item.msg_type];
      end
      if (mark_set) begin
         mfwd_row_ff  <= b2_row;
         mfwd_data_ff <= mark_row_new;
      end
      if (census_set) begin
         cfwd_addr_ff <= b2_item_ff.msg_type;
         cfwd_data_ff <= census_new;
      end
      if (b2_go) begin
         rsp_verdict_ff <= verdict;
         rsp_bytes_ff   <= kept_bytes_in;
         rsp_frames_ff  <= kept_frames_in;
         rsp_type_ff    <= census_set ? census_new : census_cur;
         rsp_unknown_ff <= kept_unknown_in;
      end
   end

   assign rsp_valid              = rsp_valid_ff;
   assign rsp_verdict            = rsp_verdict_ff;
   assign rsp_bytes_kept_total   = rsp_bytes_ff;
   assign rsp_frames_kept_total  = rsp_frames_ff;
   assign rsp_type_kept_count    = rsp_type_ff;
   assign rsp_unknown_kept_total = rsp_unknown_ff;

endmodule

// File: rtl/core/itch_symbol_message_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ITCH 5.0 symbol message filter
// Per-message keep/drop decision on ITCH 5.0 headers with running counters.
// ----------------------------------------------------------------------------
// One req beat carries one message header (type, stock locate, length prefix
// value, 8-byte stock field) and produces exactly one rsp beat with the
// verdict and the kept-byte, kept-frame, per-type census and unknown-type
// counters as they stand after that message. The filter sustains one beat
// per clock while rsp_ready is high: a front end checks the length against
// the ITCH 5.0 table and matches directory ('R') stock fields against the
// configured symbols, a four-entry queue decouples it from the back end,
// and the back end reads the locate-mark row and census entry into its
// execute registers as it pops a message, then decides and writes back
// from them while it reads the next. A message passes from req via a queue
// entry and the execute registers to the result register. After reset the
// locate-mark memory is swept clear one 64-mark row per cycle while
// req_ready stays low; CSR writes are taken throughout. Length errors and
// the byte ceiling set a sticky halt; from then on every beat returns the
// halted verdict until reset. Write CSRs only with no message in flight.
// ----------------------------------------------------------------------------
module itch_symbol_message_filter (
   input  logic                           clock,
   input  logic                           reset,
   // configuration
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ismf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ismf_pkg::SYMBOL_W-1:0]  csr_data,
   // message headers in
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [7:0]                     req_msg_type,
   input  logic [15:0]                    req_stock_locate,
   input  logic [15:0]                    req_msg_length,
   input  logic [ismf_pkg::SYMBOL_W-1:0]  req_stock_field,
   // results out
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [2:0]                     rsp_verdict,
   output logic [ismf_pkg::CNT_W-1:0]     rsp_bytes_kept_total,
   output logic [ismf_pkg::CNT_W-1:0]     rsp_frames_kept_total,
   output logic [ismf_pkg::CNT_W-1:0]     rsp_type_kept_count,
   output logic [ismf_pkg::CNT_W-1:0]     rsp_unknown_kept_total
);
   import ismf_pkg::*;

   cfg_type  cfg;
   logic     push, pop, queue_full, head_valid, clear_busy;
   work_type push_item, head_item;

   // configuration registers
   ismf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // front end: accept and classify
   ismf_front u_front (
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_msg_type     (req_msg_type),
      .req_stock_locate (req_stock_locate),
      .req_msg_length   (req_msg_length),
      .req_stock_field  (req_stock_field),
      .cfg              (cfg),
      .queue_full       (queue_full),
      .clear_busy       (clear_busy),
      .push             (push),
      .push_item        (push_item)
   );

   // decoupling queue
   ismf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item),
      .full       (queue_full)
   );

   // back end: marks, census, counters, halt, result register
   ismf_back u_back (
      .clock                  (clock),
      .reset                  (reset),
      .cfg                    (cfg),
      .head_valid             (head_valid),
      .head_item              (head_item),
      .pop                    (pop),
      .clear_busy             (clear_busy),
      .rsp_valid              (rsp_valid),
      .rsp_ready              (rsp_ready),
      .rsp_verdict            (rsp_verdict),
      .rsp_bytes_kept_total   (rsp_bytes_kept_total),
      .rsp_frames_kept_total  (rsp_frames_kept_total),
      .rsp_type_kept_count    (rsp_type_kept_count),
      .rsp_unknown_kept_total (rsp_unknown_kept_total)
   );

endmodule

// File: rtl/core/ismf_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ISMF port checker
// Watches the result channel: halt stickiness, counter steps, stall hold.
// ----------------------------------------------------------------------------
module ismf_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [2:0]                 rsp_verdict,
   input logic [ismf_pkg::CNT_W-1:0] rsp_bytes_kept_total,
   input logic [ismf_pkg::CNT_W-1:0] rsp_frames_kept_total
);
   import ismf_pkg::*;

   logic             beat;
   logic             halt_seen_ff;
   logic [CNT_W-1:0] last_bytes_ff;
   logic [CNT_W-1:0] last_frames_ff;

   assign beat = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         halt_seen_ff   <= 1'b0;
         last_bytes_ff  <= '0;
         last_frames_ff <= '0;
      end else if (beat) begin
         last_bytes_ff  <= rsp_bytes_kept_total;
         last_frames_ff <= rsp_frames_kept_total;
         if (rsp_verdict == VERDICT_SHORT || rsp_verdict == VERDICT_MISMATCH
             || rsp_verdict == VERDICT_CEIL || rsp_verdict == VERDICT_HALTED) begin
            halt_seen_ff <= 1'b1;
         end
      end
   end

   // once halted, every later beat says so
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && halt_seen_ff |-> rsp_verdict == VERDICT_HALTED)
      else $error("beat after halt without halted verdict");

   // kept bytes never go down
   a_bytes_grow: assert property (@(posedge clock) disable iff (reset)
      beat |-> rsp_bytes_kept_total >= last_bytes_ff)
      else $error("kept byte total went down");

   // frame count steps by one on a keep and holds otherwise
   a_frames_step: assert property (@(posedge clock) disable iff (reset)
      beat |-> rsp_frames_kept_total == ((rsp_verdict == VERDICT_KEEP) ?
               last_frames_ff + CNT_W'(1) : last_frames_ff))
      else $error("frame total does not follow verdict");

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_verdict)
                                 && $stable(rsp_bytes_kept_total))
      else $error("stalled result changed");

endmodule

bind itch_symbol_message_filter ismf_checker u_ismf_checker (
   .clock                 (clock),
   .reset                 (reset),
   .rsp_valid             (rsp_valid),
   .rsp_ready             (rsp_ready),
   .rsp_verdict           (rsp_verdict),
   .rsp_bytes_kept_total  (rsp_bytes_kept_total),
   .rsp_frames_kept_total (rsp_frames_kept_total)
);
